// ===== src/ps2fr_pkg.sv =====
// Shared types and constants for the PS/2 frame receiver.
// No dependencies; imported by ps2fr_decode and ps2_frame_receiver_core.
`timescale 1ns / 1ps

package ps2fr_pkg;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_EDGE = 1'b1
  } ps2fr_cmd_e;

  // One request: a millisecond tick or a keyboard clock falling edge.
  typedef struct packed {
    logic command;
    logic data_bit;
  } ps2fr_req_t;

  // One result: the received byte and its status.
  typedef struct packed {
    logic [7:0] scan_code;
    logic       frame_ok;
  } ps2fr_rsp_t;

  // Per-frame receive state.
  typedef struct packed {
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic       parity_acc;
    logic       start_ok;
  } ps2fr_frame_t;

  localparam logic [3:0] START_EDGE     = 4'd1;
  localparam logic [3:0] LAST_DATA_EDGE = 4'd9;
  localparam logic [3:0] PARITY_EDGE    = 4'd10;
  localparam logic [3:0] STOP_EDGE      = 4'd11;
  localparam logic [7:0] HIGH_BIT       = 8'h80;
  localparam logic [7:0] GAP_RESET      = 8'd4;

endpackage

// ===== src/ps2fr_decode.sv =====
// Next-state and result logic for one request of the PS/2 frame receiver.
// Depends on ps2fr_pkg.
`timescale 1ns / 1ps

module ps2fr_decode
  import ps2fr_pkg::*;
#(
  parameter int MS_WIDTH = 16
) (
  input  ps2fr_req_t            req_i,
  input  logic [7:0]            gap_ms_i,
  input  logic [MS_WIDTH-1:0]   ms_count_i,
  input  logic [MS_WIDTH-1:0]   last_start_i,
  input  ps2fr_frame_t          frame_i,
  output logic [MS_WIDTH-1:0]   ms_count_o,
  output logic [MS_WIDTH-1:0]   last_start_o,
  output ps2fr_frame_t          frame_o,
  output logic                  rsp_valid_o,
  output ps2fr_rsp_t            rsp_o
);

  logic [3:0]          idx;
  logic [MS_WIDTH-1:0] elapsed;
  logic [7:0]          sb;
  logic                ok;

  always_comb begin
    ms_count_o   = ms_count_i;
    last_start_o = last_start_i;
    frame_o      = frame_i;
    rsp_valid_o  = 1'b0;
    rsp_o        = '0;
    idx          = frame_i.bit_index + 4'd1;
    elapsed      = ms_count_i - last_start_i;
    sb           = frame_i.shift_byte;
    ok           = frame_i.start_ok & frame_i.parity_acc & req_i.data_bit;

    if (req_i.command == CMD_TICK) begin
      ms_count_o = ms_count_i + MS_WIDTH'(1);
    end else begin
      frame_o.bit_index = idx;
      if (idx == START_EDGE) begin
        if (elapsed > MS_WIDTH'(gap_ms_i)) begin
          frame_o.start_ok = ~req_i.data_bit;
          last_start_o     = ms_count_i;
          if (!req_i.data_bit) begin
            frame_o.shift_byte = '0;
            frame_o.parity_acc = 1'b1;
          end else begin
            frame_o.bit_index = '0;
          end
        end else begin
          frame_o.bit_index = '0;
        end
      end else if (idx > START_EDGE && idx < PARITY_EDGE) begin
        if (req_i.data_bit) begin
          sb                 = sb | HIGH_BIT;
          frame_o.parity_acc = ~frame_i.parity_acc;
        end
        // last data bit stays in the top position
        if (idx < LAST_DATA_EDGE) begin
          sb = sb >> 1;
        end
        frame_o.shift_byte = sb;
      end else if (idx == PARITY_EDGE) begin
        frame_o.parity_acc = (frame_i.parity_acc == req_i.data_bit);
      end else if (idx == STOP_EDGE) begin
        if (!ok) begin
          frame_o.shift_byte = '0;
        end
        frame_o.bit_index = '0;
        rsp_valid_o       = 1'b1;
        rsp_o.scan_code   = ok ? frame_i.shift_byte : 8'd0;
        rsp_o.frame_ok    = ok;
      end
    end
  end

endmodule

// ===== src/ps2_frame_receiver_core.sv =====
// Top level of the PS/2 keyboard frame receiver: input register, state and
// result register. Depends on ps2fr_pkg and ps2fr_decode.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// in        in   in_valid_i / in_ready_o  in_req_i   (command, data_bit)
// out       out  out_valid_o / out_ready_i out_rsp_o (scan_code, frame_ok)
// cfg       in   cfg_we_i                 cfg_wdata_i (gap_ms)
//
// One request per cycle is accepted while no stop edge is held back in the
// input register. A request passes the input register and then updates the
// state; a stop edge's result is loaded into the result register at that
// same edge and shows on out from there.
// Reset clears the state, the valid flags and sets gap_ms to 4.
// A stall on out holds back only a stop-edge request waiting in the input
// register; ticks and other edges keep flowing while a result waits.
module ps2_frame_receiver_core
  import ps2fr_pkg::*;
#(
  parameter int MS_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ps2fr_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ps2fr_rsp_t out_rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // config
  logic [7:0] gap_ms_q;

  // input register
  logic       item_valid_q;
  ps2fr_req_t item_q;

  // receiver state
  logic [MS_WIDTH-1:0] ms_count_q, ms_count_d;
  logic [MS_WIDTH-1:0] last_start_q, last_start_d;
  ps2fr_frame_t        frame_q, frame_d;

  // result register
  logic       out_valid_q;
  ps2fr_rsp_t out_q;

  logic       rsp_valid;
  ps2fr_rsp_t rsp;
  logic       out_free;
  logic       advance;

  ps2fr_decode #(
    .MS_WIDTH(MS_WIDTH)
  ) u_decode (
    .req_i       (item_q),
    .gap_ms_i    (gap_ms_q),
    .ms_count_i  (ms_count_q),
    .last_start_i(last_start_q),
    .frame_i     (frame_q),
    .ms_count_o  (ms_count_d),
    .last_start_o(last_start_d),
    .frame_o     (frame_d),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  // stored request retires unless its result has nowhere to go
  assign advance    = item_valid_q && (!rsp_valid || out_free);
  assign in_ready_o = !item_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ms_q <= GAP_RESET;
    end else if (cfg_we_i) begin
      gap_ms_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_count_q   <= '0;
      last_start_q <= '0;
      frame_q      <= '0;
    end else if (advance) begin
      ms_count_q   <= ms_count_d;
      last_start_q <= last_start_d;
      frame_q      <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && rsp_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rsp_valid) begin
      out_q <= rsp;
    end
  end

`ifndef ASSERT_OFF
  // the stop edge always delivers a result next cycle
  a_stop_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.command == CMD_EDGE && frame_q.bit_index == PARITY_EDGE
    |=> out_valid_o)
    else $error("stop edge produced no result");

  // a tick advances the time counter by exactly one
  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.command == CMD_TICK
    |=> ms_count_q == MS_WIDTH'($past(ms_count_q) + MS_WIDTH'(1)))
    else $error("tick did not advance ms counter");

  // a frame in progress implies a good start bit was seen
  a_frame_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.bit_index != 4'd0 |-> frame_q.start_ok)
    else $error("frame in progress without valid start");

  // failed frames report a zero code
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rsp_valid && !rsp.frame_ok |=> out_rsp_o.scan_code == 8'd0)
    else $error("failed frame with nonzero code");
`endif

endmodule
